// File: hdl/gbr_pkg.sv
package gbr_pkg;

  localparam int unsigned CH_W        = 8;
  localparam int unsigned N_CH        = 3;
  localparam int unsigned PIX_W       = CH_W * N_CH;
  localparam int unsigned KSIZE       = 5;
  localparam int unsigned N_LINES     = KSIZE - 1;
  localparam int unsigned EDGE        = KSIZE - 1;
  localparam int unsigned MIN_DIM     = 5;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned WID_W       = 11;
  localparam int unsigned HGT_W       = 13;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned COL_FIELD_W = 12;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned N_GRP       = 6;

  localparam logic [WID_W-1:0] RST_WIDTH  = WID_W'(640);
  localparam logic [HGT_W-1:0] RST_HEIGHT = HGT_W'(480);

  // kernel weights in thousandths, one per symmetry group
  localparam int unsigned COEF_MILLI [N_GRP] = '{3, 13, 22, 59, 97, 159};

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_last;
  } pix_out_t;

  typedef struct packed {
    pix_in_t                pix;
    logic [COL_FIELD_W-1:0] col;
    logic                   emit;
    logic                   last;
  } item_t;

  typedef struct packed {
    logic vld;
    logic last;
  } tap_ctl_t;

  typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] win_t;

endpackage

// File: hdl/gaussian_blur_5x5_rgb_top.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_ready_o  pix_in_t  (red_in, green_in, blue_in)
// out       output     out_valid_o/out_ready_i  pix_out_t (red/green/blue_out, frame_last)
// cfg       input      APB, pready tied high    image_width @0x0, image_height @0x4
//
// One pixel per clock sustained while the output is ready; an accepted interior pixel
// runs through line-store read, window, group sums, products, sum into output.
// The line-store memory takes one read and one write per cycle, which sets that rate.
// Reset clears counters and valid flags; line-store contents stay undefined.
// A stalled output freezes the filter pipeline; the input keeps filling a four-entry
// queue and stalls only once that is full.
module gaussian_blur_5x5_rgb_top import gbr_pkg::*; #(
  parameter int unsigned MAX_WIDTH      = 1024,
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pix_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pix_out_t          out_data_o
);

  logic [WID_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;
  reg_idx_e         reg_idx;
  logic             push_vld, push_ready, pop_vld, adv;
  item_t            push_item, pop_item;
  tap_ctl_t         tap_ctl;
  win_t             win;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_AW-1]);

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = APB_DW'(width_q);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(height_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:  width_q  <= pwdata[WID_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata[HGT_W-1:0];
        default:          ;
      endcase
    end
  end

  gbr_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_vld_o   (push_vld),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  gbr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_vld_i   (push_vld),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_vld_o    (pop_vld),
    .pop_ready_i  (adv),
    .pop_item_o   (pop_item)
  );

  gbr_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .pop_vld_i  (pop_vld),
    .pop_item_i (pop_item),
    .tap_ctl_o  (tap_ctl),
    .win_o      (win)
  );

  gbr_filter #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tap_ctl_i   (tap_ctl),
    .win_i       (win),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hdl/gbr_front.sv
module gbr_front import gbr_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WID_W-1:0] cfg_width_i,
  input  logic [HGT_W-1:0] cfg_height_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pix_in_t          in_data_i,
  output logic             push_vld_o,
  input  logic             push_ready_i,
  output item_t            push_item_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);

  logic [COL_W-1:0] col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic [WW-1:0]    w_eff, col_inc;
  logic [HGT_W-1:0] h_eff, row_t, row_inc;
  logic             accept;

  assign accept     = in_valid_i && push_ready_i;
  assign in_ready_o = push_ready_i;
  assign push_vld_o = in_valid_i;

  always_comb begin
    if (cfg_width_i < WID_W'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (int'(cfg_width_i) > int'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_i);
    end
    if (cfg_height_i < HGT_W'(MIN_DIM)) begin
      h_eff = HGT_W'(MIN_DIM);
    end else if (cfg_height_i > HGT_W'(MAX_HEIGHT)) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_height_i;
    end
  end

  always_comb begin
    if (WW'(col_q) >= w_eff) begin
      col_cur = '0;
      row_t   = HGT_W'(row_q) + HGT_W'(1);
    end else begin
      col_cur = col_q;
      row_t   = HGT_W'(row_q);
    end
    row_cur = (row_t >= h_eff) ? '0 : row_t[ROW_W-1:0];

    col_inc = WW'(col_cur) + WW'(1);
    row_inc = HGT_W'(row_cur) + HGT_W'(1);
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_d = col_inc[COL_W-1:0];
      row_d = row_cur;
    end

    push_item_o.pix  = in_data_i;
    push_item_o.col  = COL_FIELD_W'(col_cur);
    push_item_o.emit = (row_cur >= ROW_W'(EDGE)) && (col_cur >= COL_W'(EDGE));
    push_item_o.last = (HGT_W'(row_cur) == h_eff - HGT_W'(1))
                    && (WW'(col_cur) == w_eff - WW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// File: hdl/gbr_queue.sv
module gbr_queue import gbr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_vld_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_vld_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  item_t         fifo_q [QDEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != CW'(QDEPTH));
  assign pop_vld_o    = (cnt_q != '0);
  assign pop_item_o   = fifo_q[rd_ptr_q];
  assign push         = push_vld_i && push_ready_o;
  assign pop          = pop_vld_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: hdl/gbr_window.sv
module gbr_window import gbr_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     pop_vld_i,
  input  item_t    pop_item_i,
  output tap_ctl_t tap_ctl_o,
  output win_t     win_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic [N_LINES-1:0][PIX_W-1:0] line_mem_q [MAX_WIDTH];
  logic [N_LINES-1:0][PIX_W-1:0] rd_q, wr_word;
  logic [KSIZE-1:0][PIX_W-1:0]   col_w;
  item_t                         s1_item_q;
  logic                          s1_vld_q;
  tap_ctl_t                      tap_ctl_q;
  win_t                          win_q, win_d;

  always_comb begin
    for (int k = 0; k < N_LINES; k++) begin
      col_w[k] = rd_q[k];
    end
    col_w[KSIZE-1] = PIX_W'(s1_item_q.pix);
    for (int k = 0; k < N_LINES; k++) begin
      wr_word[k] = col_w[k+1];
    end
    for (int r = 0; r < KSIZE; r++) begin
      for (int c = 0; c < KSIZE - 1; c++) begin
        win_d[r][c] = win_q[r][c+1];
      end
      win_d[r][KSIZE-1] = col_w[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rd_q      <= line_mem_q[pop_item_i.col[AW-1:0]];
      s1_item_q <= pop_item_i;
      if (s1_vld_q) begin
        line_mem_q[s1_item_q.col[AW-1:0]] <= wr_word;
        win_q                             <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      tap_ctl_q <= '0;
    end else if (adv_i) begin
      s1_vld_q       <= pop_vld_i;
      tap_ctl_q.vld  <= s1_vld_q && s1_item_q.emit;
      tap_ctl_q.last <= s1_item_q.last;
    end
  end

  assign tap_ctl_o = tap_ctl_q;
  assign win_o     = win_q;

endmodule

// File: hdl/gbr_filter.sv
module gbr_filter import gbr_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tap_ctl_t tap_ctl_i,
  input  win_t     win_i,
  output logic     adv_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pix_out_t out_data_o
);

  localparam int unsigned CW = COEF_FRAC_BITS - 2;
  localparam int unsigned GW = CH_W + 3;
  localparam int unsigned PW = GW + CW;
  localparam int unsigned SW = PW + 3;
  localparam int unsigned RW = SW - COEF_FRAC_BITS;

  logic [CW-1:0] coef [N_GRP];

  for (genvar g = 0; g < N_GRP; g++) begin : g_coef
    localparam int unsigned COEF_FIX = ((COEF_MILLI[g] << COEF_FRAC_BITS) + 500) / 1000;
    assign coef[g] = CW'(COEF_FIX);
  end

  function automatic logic [GW-1:0] px(win_t w, int r, int c, int ch);
    return GW'(w[r][c][CH_W*(N_CH-1-ch) +: CH_W]);
  endfunction

  logic [GW-1:0]   grp_d  [N_CH][N_GRP];
  logic [GW-1:0]   grp_q  [N_CH][N_GRP];
  logic [PW-1:0]   prod_q [N_CH][N_GRP];
  logic [SW-1:0]   sum    [N_CH];
  logic [RW-1:0]   shr    [N_CH];
  logic [CH_W-1:0] res    [N_CH];
  tap_ctl_t        a_ctl_q, b_ctl_q;
  pix_out_t        out_q;
  logic            out_vld_q, adv;

  assign adv   = !out_vld_q || out_ready_i;
  assign adv_o = adv;

  always_comb begin
    for (int ch = 0; ch < N_CH; ch++) begin
      grp_d[ch][0] = px(win_i, 0, 0, ch) + px(win_i, 0, 4, ch)
                   + px(win_i, 4, 0, ch) + px(win_i, 4, 4, ch);
      grp_d[ch][1] = px(win_i, 0, 1, ch) + px(win_i, 0, 3, ch)
                   + px(win_i, 1, 0, ch) + px(win_i, 1, 4, ch)
                   + px(win_i, 3, 0, ch) + px(win_i, 3, 4, ch)
                   + px(win_i, 4, 1, ch) + px(win_i, 4, 3, ch);
      grp_d[ch][2] = px(win_i, 0, 2, ch) + px(win_i, 2, 0, ch)
                   + px(win_i, 2, 4, ch) + px(win_i, 4, 2, ch);
      grp_d[ch][3] = px(win_i, 1, 1, ch) + px(win_i, 1, 3, ch)
                   + px(win_i, 3, 1, ch) + px(win_i, 3, 3, ch);
      grp_d[ch][4] = px(win_i, 1, 2, ch) + px(win_i, 2, 1, ch)
                   + px(win_i, 2, 3, ch) + px(win_i, 3, 2, ch);
      grp_d[ch][5] = px(win_i, 2, 2, ch);
    end
  end

  always_comb begin
    for (int ch = 0; ch < N_CH; ch++) begin
      sum[ch] = '0;
      for (int g = 0; g < N_GRP; g++) begin
        sum[ch] = sum[ch] + SW'(prod_q[ch][g]);
      end
      shr[ch] = sum[ch][SW-1:COEF_FRAC_BITS];
      res[ch] = (shr[ch] > RW'(255)) ? CH_W'(255) : shr[ch][CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int ch = 0; ch < N_CH; ch++) begin
        for (int g = 0; g < N_GRP; g++) begin
          grp_q[ch][g]  <= grp_d[ch][g];
          prod_q[ch][g] <= PW'(grp_q[ch][g]) * PW'(coef[g]);
        end
      end
      out_q.red_out    <= res[0];
      out_q.green_out  <= res[1];
      out_q.blue_out   <= res[2];
      out_q.frame_last <= b_ctl_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q   <= '0;
      b_ctl_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      a_ctl_q   <= tap_ctl_i;
      b_ctl_q   <= a_ctl_q;
      out_vld_q <= b_ctl_q.vld;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// File: verif/gbr_blur_checker.sv
module gbr_blur_checker import gbr_pkg::*; #(
  parameter int unsigned MAX_W     = 1024,
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  pix_in_t           in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  pix_out_t          out_data_i,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  bit [PIX_W-1:0]   line_mem [N_LINES][MAX_W];
  bit [PIX_W-1:0]   win [KSIZE][KSIZE];
  int unsigned      weight [KSIZE][KSIZE];
  logic [WID_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      faults = 0;
  int unsigned      checked = 0;
  pix_out_t         blurred_q [$];

  initial begin
    int unsigned dr;
    int unsigned dc;
    int unsigned milli;
    for (int r = 0; r < KSIZE; r++) begin
      for (int c = 0; c < KSIZE; c++) begin
        dr = (r > 2) ? r - 2 : 2 - r;
        dc = (c > 2) ? c - 2 : 2 - c;
        case (dr * 3 + dc)
          0:       milli = 159;
          1, 3:    milli = 97;
          2, 6:    milli = 22;
          4:       milli = 59;
          5, 7:    milli = 13;
          default: milli = 3;
        endcase
        weight[r][c] = ((milli << FRAC_BITS) + 500) / 1000;
      end
    end
  end

  function automatic logic [CH_W-1:0] blur_channel(int unsigned lsb);
    longint unsigned acc;
    acc = 0;
    for (int r = 0; r < KSIZE; r++) begin
      for (int c = 0; c < KSIZE; c++) begin
        acc += longint'(win[r][c][lsb +: CH_W]) * weight[r][c];
      end
    end
    acc >>= FRAC_BITS;
    return (acc > 255) ? 8'hFF : CH_W'(acc);
  endfunction

  task automatic take_pixel(pix_in_t pix);
    int unsigned    w;
    int unsigned    h;
    bit [PIX_W-1:0] taps [KSIZE];
    pix_out_t       res;
    w = (width_q < MIN_DIM) ? MIN_DIM : ((width_q > MAX_W) ? MAX_W : width_q);
    h = (height_q < MIN_DIM) ? MIN_DIM : ((height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q);
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    for (int k = 0; k < N_LINES; k++) taps[k] = line_mem[k][col_pos];
    taps[N_LINES] = PIX_W'(pix);
    for (int k = 0; k < N_LINES; k++) line_mem[k][col_pos] = taps[k + 1];
    for (int r = 0; r < KSIZE; r++) begin
      for (int c = 0; c < KSIZE - 1; c++) win[r][c] = win[r][c + 1];
      win[r][KSIZE - 1] = taps[r];
    end
    if (row_pos >= EDGE && col_pos >= EDGE) begin
      res.red_out    = blur_channel(2 * CH_W);
      res.green_out  = blur_channel(CH_W);
      res.blue_out   = blur_channel(0);
      res.frame_last = (row_pos == h - 1) && (col_pos == w - 1);
      blurred_q.push_back(res);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic check_result(pix_out_t got);
    pix_out_t want;
    if (blurred_q.size() == 0) begin
      faults++;
      if (faults <= REPORT_LIMIT) begin
        $display("unexpected blurred pixel r=%0d g=%0d b=%0d last=%0b",
                 got.red_out, got.green_out, got.blue_out, got.frame_last);
      end
      return;
    end
    want = blurred_q.pop_front();
    checked++;
    if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
        got.blue_out !== want.blue_out || got.frame_last !== want.frame_last) begin
      faults++;
      if (faults <= REPORT_LIMIT) begin
        $display("blurred pixel %0d: expected r=%0d g=%0d b=%0d last=%0b",
                 checked, want.red_out, want.green_out, want.blue_out, want.frame_last);
        $display("  got r=%0d g=%0d b=%0d last=%0b",
                 got.red_out, got.green_out, got.blue_out, got.frame_last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  = RST_WIDTH;
      height_q = RST_HEIGHT;
      col_pos  = 0;
      row_pos  = 0;
      for (int r = 0; r < KSIZE; r++) begin
        for (int c = 0; c < KSIZE; c++) win[r][c] = '0;
      end
      blurred_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) take_pixel(in_data_i);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i >> 2))
          REG_IMAGE_WIDTH:  width_q = pwdata_i[WID_W-1:0];
          REG_IMAGE_HEIGHT: height_q = pwdata_i[HGT_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches_o <= faults;
    pending_o    <= blurred_q.size();
    checked_o    <= checked;
  end

endmodule

// File: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gbr_pkg::*;

  localparam int unsigned MAX_WIDTH     = 1024;
  localparam int unsigned FRAC_BITS     = 12;
  localparam int unsigned RANDOM_PIXELS = 600;
  localparam int unsigned FILL_WIDTH    = 24;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned NO_PAUSE      = '1;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  pix_in_t           in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  pix_out_t          out_data_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned stall_pct = 0;
  bit          ready_forced = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned pixels_sent = 0;
  int unsigned phases = 0;
  int unsigned cfg_writes = 0;
  pix_in_t     pixel_feed [$];

  gaussian_blur_5x5_rgb_top #(
    .MAX_WIDTH      (MAX_WIDTH),
    .COEF_FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  gbr_blur_checker #(
    .MAX_W     (MAX_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) blur_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ready_forced || stall_pct == 0 || $urandom_range(99) >= stall_pct;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [CH_W-1:0] pick_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  function automatic pix_in_t random_pixel();
    return {pick_level(), pick_level(), pick_level()};
  endfunction

  task automatic cfg_write(input reg_idx_e idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(idx));
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    cfg_writes++;
  endtask

  // send the queued pixels, then drain and let the pipeline go quiet
  task automatic stream_pixels(input idle_mode_e mode, input int unsigned pause_at);
    int unsigned gap_pct;
    int unsigned idx;
    case (mode)
      IDLE_SEND: begin
        gap_pct   = 57;
        stall_pct = 0;
      end
      IDLE_RECV: begin
        gap_pct   = 0;
        stall_pct = 57;
      end
      IDLE_BOTH: begin
        gap_pct   = 15;
        stall_pct = 15;
      end
      default: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
    endcase
    idx = 0;
    while (pixel_feed.size() != 0) begin
      if (idx == pause_at) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      while ($urandom_range(99) < gap_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= pixel_feed.pop_front();
      do @(posedge clk_i); while (!in_ready_o);
      idx++;
      pixels_sent++;
    end
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    ready_forced = 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    ready_forced = 1'b0;
    phases++;
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned n;
    int unsigned new_w;
    int unsigned new_h;
    random_sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // smallest frame, both sizes below range
    cfg_write(REG_IMAGE_WIDTH, 0);
    cfg_write(REG_IMAGE_HEIGHT, 4);
    for (int i = 0; i < 25; i++) begin
      pixel_feed.push_back({8'hFF, 8'h00, (i % 2) ? 8'hAA : 8'h55});
    end
    stream_pixels(IDLE_NONE, NO_PAUSE);

    // one whole frame of the widest rows used later, filling those line-store columns
    cfg_write(REG_IMAGE_WIDTH, FILL_WIDTH);
    cfg_write(REG_IMAGE_HEIGHT, MIN_DIM);
    repeat (MIN_DIM * FILL_WIDTH) pixel_feed.push_back(random_pixel());
    stream_pixels(IDLE_BOTH, 100);

    // width above range, kept within the first row
    cfg_write(REG_IMAGE_WIDTH, 2047);
    repeat (28) pixel_feed.push_back(random_pixel());
    stream_pixels(IDLE_RECV, NO_PAUSE);

    cfg_write(REG_IMAGE_WIDTH, MIN_DIM);
    cfg_write(REG_IMAGE_HEIGHT, MAX_HEIGHT);
    repeat (40) pixel_feed.push_back(random_pixel());
    stream_pixels(IDLE_SEND, NO_PAUSE);

    while (random_sent < RANDOM_PIXELS) begin
      case ($urandom_range(11))
        0:       new_w = $urandom_range(4);
        1:       new_w = MIN_DIM;
        2:       new_w = FILL_WIDTH;
        default: new_w = $urandom_range(6, FILL_WIDTH);
      endcase
      case ($urandom_range(9))
        0:       new_h = $urandom_range(4);
        1:       new_h = MIN_DIM;
        2:       new_h = $urandom_range(MAX_HEIGHT, 8191);
        default: new_h = $urandom_range(6, 10);
      endcase
      if ($urandom_range(99) < 70) cfg_write(REG_IMAGE_WIDTH, new_w);
      if ($urandom_range(99) < 70) cfg_write(REG_IMAGE_HEIGHT, new_h);
      n = $urandom_range(30, 110);
      repeat (n) pixel_feed.push_back(random_pixel());
      stream_pixels(idle_mode_e'(phases % 4),
                    ($urandom_range(3) == 0) ? $urandom_range(n - 1) : NO_PAUSE);
      random_sent += n;
    end

    $display("Streamed %0d pixels over %0d phases with %0d register writes;",
             pixels_sent, phases, cfg_writes);
    $display("checked %0d blurred pixels, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
